[rtl/text_encoding_transcoder_top_defines.svh]
// assertion macros for the text encoding transcoder checker
// no dependencies; included by the checker file only
`ifndef TEXT_ENCODING_TRANSCODER_TOP_DEFINES_SVH
`define TEXT_ENCODING_TRANSCODER_TOP_DEFINES_SVH

// property checked only while out of reset
`define TET_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define TET_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/tet_pkg.sv]
// shared types, codes and mapping functions of the text encoding transcoder
// no dependencies; imported by the top, decode, encode and serial modules
package tet_pkg;

  // encoding codes (0 and 1 both select cp866)
  localparam logic [1:0] ENC_CP866 = 2'd0;
  localparam logic [1:0] ENC_UTF16 = 2'd2;
  localparam logic [1:0] ENC_UTF8  = 2'd3;

  // configuration register indexes
  localparam logic CFG_SRC = 1'b0;
  localparam logic CFG_DST = 1'b1;

  localparam int unsigned CP_W = 21;

  // character constants
  localparam logic [7:0]  CH_QUEST   = 8'h3F;
  localparam logic [10:0] CP_CYR_A   = 11'h410;
  localparam logic [10:0] CP_CYR_R   = 11'h440;
  localparam logic [10:0] CP_CYR_END = 11'h450;
  localparam logic [10:0] CP_YO_UP   = 11'h401;
  localparam logic [10:0] CP_YO_LO   = 11'h451;
  localparam logic [7:0]  B866_YO_UP = 8'hF0;
  localparam logic [7:0]  B866_YO_LO = 8'hF1;

  // decoded character handed to the encoder
  typedef struct packed {
    logic            valid;
    logic            term;
    logic [CP_W-1:0] cp;
  } char_t;

  // encoded bytes of one character
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
  } enc_t;

  // cp866 byte to code point
  function automatic logic [10:0] cp866_decode(input logic [7:0] b);
    logic [10:0] r;
    if (b < 8'h80)       r = {3'b000, b};
    else if (b < 8'hB0)  r = {3'b000, b} + (CP_CYR_A - 11'h080);
    else if (b < 8'hE0)  r = {3'b000, CH_QUEST};
    else if (b < 8'hF0)  r = {3'b000, b} + (CP_CYR_R - 11'h0E0);
    else if (b == B866_YO_UP) r = CP_YO_UP;
    else if (b == B866_YO_LO) r = CP_YO_LO;
    else                 r = {3'b000, CH_QUEST};
    return r;
  endfunction

  // code point to cp866 byte, unmappable gives '?'
  function automatic logic [7:0] cp866_encode(input logic [CP_W-1:0] ch);
    logic [7:0] r;
    if (ch < 21'h80)                       r = ch[7:0];
    else if (ch == {10'd0, CP_YO_UP})      r = B866_YO_UP;
    else if (ch < {10'd0, CP_CYR_A})       r = CH_QUEST;
    else if (ch < {10'd0, CP_CYR_R})       r = ch[7:0] + 8'h70;
    else if (ch < {10'd0, CP_CYR_END})     r = ch[7:0] + 8'hA0;
    else if (ch == {10'd0, CP_YO_LO})      r = B866_YO_LO;
    else                                   r = CH_QUEST;
    return r;
  endfunction

endpackage

[rtl/text_encoding_transcoder_top.sv]
// top level of the text encoding transcoder
// depends on tet_pkg, tet_decode, tet_encode, tet_serial
//
// Usage:
//   in_*  : one source byte per item in in_tdata[7:0].
//   out_* : one destination byte per item in out_tdata[7:0]; out_tlast marks
//           the last byte caused by one source byte, out_tuser marks the
//           final byte of the string terminator.
//   cfg_* : cfg_index 0 selects the source encoding, 1 the destination
//           (0/1 cp866, 2 utf-16le, 3 utf-8); any write drops a partial
//           character. Write only while no bytes are in flight.
// Latency: the first byte of a completed character shows in the cycle after
//   its last source byte is taken. A source byte is taken every cycle while
//   each character encodes to one byte and the receiver is ready; a character
//   of several bytes holds the input until its final byte leaves the single
//   output register, which sends the bytes one per cycle while out_tready is high.
// Reset (rst_n low, synchronous) selects cp866 both ways and clears all
//   partial state. When the receiver stalls, the output byte holds and the
//   input is not taken until the final byte of the character leaves.
module text_encoding_transcoder_top
  import tet_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tuser,  // [0] end_of_string
  output logic       out_tlast,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [1:0] cfg_wdata
);

  logic [1:0] src_r;
  logic [1:0] dst_r;
  logic       accept;
  logic       can_load;
  char_t      chr;
  enc_t       enc;

  assign in_tready = can_load;
  assign accept    = in_tvalid & in_tready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_r <= ENC_CP866;
      dst_r <= ENC_CP866;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SRC: src_r <= cfg_wdata;
        CFG_DST: dst_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  tet_decode u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .in_byte  (in_tdata),
    .src_code (src_r),
    .clear    (cfg_we),
    .chr      (chr)
  );

  tet_encode u_encode (
    .dst_code (dst_r),
    .cp       (chr.cp),
    .enc      (enc)
  );

  tet_serial u_serial (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (chr.valid),
    .load_term  (chr.term),
    .enc        (enc),
    .can_load   (can_load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

[rtl/tet_decode.sv]
// source decoder: partial-character state and code point assembly
// depends on tet_pkg
module tet_decode
  import tet_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] in_byte,
  input  logic [1:0] src_code,
  input  logic       clear,
  output char_t      chr
);

  logic [CP_W-1:0] acc_r, acc_nxt;
  logic [1:0]      pend_r, pend_nxt;
  logic            held_r, held_nxt;
  logic [CP_W-1:0] acc_shift;
  logic [1:0]      pend_dec;
  logic            valid;
  logic [CP_W-1:0] cp;

  assign acc_shift = {acc_r[CP_W-7:0], in_byte[5:0]};
  assign pend_dec  = pend_r - 2'd1;

  // decode one item and work out the next partial state
  always_comb begin
    acc_nxt  = acc_r;
    pend_nxt = pend_r;
    held_nxt = held_r;
    valid    = 1'b0;
    cp       = '0;
    if (src_code == ENC_UTF16) begin
      if (!held_r) begin
        acc_nxt  = {{(CP_W-8){1'b0}}, in_byte};
        held_nxt = 1'b1;
      end else begin
        cp       = {{(CP_W-16){1'b0}}, in_byte, acc_r[7:0]};
        valid    = 1'b1;
        acc_nxt  = '0;
        pend_nxt = '0;
        held_nxt = 1'b0;
      end
    end else if (src_code == ENC_UTF8) begin
      if (pend_r != 2'd0) begin
        if (pend_dec != 2'd0) begin
          acc_nxt  = acc_shift;
          pend_nxt = pend_dec;
        end else begin
          cp       = acc_shift;
          valid    = 1'b1;
          acc_nxt  = '0;
          pend_nxt = '0;
          held_nxt = 1'b0;
        end
      end else if (in_byte < 8'h80) begin
        cp    = {{(CP_W-8){1'b0}}, in_byte};
        valid = 1'b1;
      end else if (in_byte < 8'hC0 || in_byte >= 8'hF8) begin
        cp    = {{(CP_W-8){1'b0}}, CH_QUEST};
        valid = 1'b1;
      end else if (in_byte < 8'hE0) begin
        acc_nxt  = {{(CP_W-5){1'b0}}, in_byte[4:0]};
        pend_nxt = 2'd1;
      end else if (in_byte < 8'hF0) begin
        acc_nxt  = {{(CP_W-4){1'b0}}, in_byte[3:0]};
        pend_nxt = 2'd2;
      end else begin
        acc_nxt  = {{(CP_W-3){1'b0}}, in_byte[2:0]};
        pend_nxt = 2'd3;
      end
    end else begin
      cp    = {{(CP_W-11){1'b0}}, cp866_decode(in_byte)};
      valid = 1'b1;
    end
    // a zero character ends the string and drops all partial state
    if (valid && cp == '0) begin
      acc_nxt  = '0;
      pend_nxt = '0;
      held_nxt = 1'b0;
    end
  end

  assign chr.valid = accept & valid;
  assign chr.term  = (cp == '0);
  assign chr.cp    = cp;

  // partial-character state
  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      acc_r  <= '0;
      pend_r <= '0;
      held_r <= 1'b0;
    end else if (accept) begin
      acc_r  <= acc_nxt;
      pend_r <= pend_nxt;
      held_r <= held_nxt;
    end
  end

endmodule

[rtl/tet_encode.sv]
// destination encoder: code point to one to four bytes
// depends on tet_pkg
module tet_encode
  import tet_pkg::*;
(
  input  logic [1:0]      dst_code,
  input  logic [CP_W-1:0] cp,
  output enc_t            enc
);

  always_comb begin
    enc.bytes    = '0;
    enc.last_idx = 2'd0;
    if (dst_code == ENC_UTF16) begin
      enc.bytes[0] = cp[7:0];
      enc.bytes[1] = cp[15:8];
      enc.last_idx = 2'd1;
    end else if (dst_code == ENC_UTF8) begin
      if (cp < 21'h80) begin
        enc.bytes[0] = cp[7:0];
      end else if (cp < 21'h800) begin
        enc.bytes[0] = {3'b110, cp[10:6]};
        enc.bytes[1] = {2'b10, cp[5:0]};
        enc.last_idx = 2'd1;
      end else if (cp < 21'h10000) begin
        enc.bytes[0] = {4'b1110, cp[15:12]};
        enc.bytes[1] = {2'b10, cp[11:6]};
        enc.bytes[2] = {2'b10, cp[5:0]};
        enc.last_idx = 2'd2;
      end else begin
        enc.bytes[0] = {5'b11110, cp[20:18]};
        enc.bytes[1] = {2'b10, cp[17:12]};
        enc.bytes[2] = {2'b10, cp[11:6]};
        enc.bytes[3] = {2'b10, cp[5:0]};
        enc.last_idx = 2'd3;
      end
    end else begin
      enc.bytes[0] = cp866_encode(cp);
    end
  end

endmodule

[rtl/tet_serial.sv]
// result register: holds one encoded character and sends it byte by byte
// depends on tet_pkg
module tet_serial
  import tet_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  logic       load_term,
  input  enc_t       enc,
  output logic       can_load,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,
  output logic       out_tuser,
  output logic       out_tlast
);

  logic            valid_r;
  logic [3:0][7:0] bytes_r;
  logic [1:0]      last_r;
  logic [1:0]      idx_r;
  logic            term_r;

  assign out_tvalid = valid_r;
  assign out_tdata  = bytes_r[idx_r];
  assign out_tlast  = (idx_r == last_r);
  assign out_tuser  = term_r & out_tlast;
  // free once the final byte leaves
  assign can_load   = !valid_r || (out_tready && out_tlast);

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else if (load) begin
      valid_r <= 1'b1;
      idx_r   <= '0;
    end else if (valid_r && out_tready) begin
      if (out_tlast) valid_r <= 1'b0;
      else idx_r <= idx_r + 2'd1;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      bytes_r <= enc.bytes;
      last_r  <= enc.last_idx;
      term_r  <= load_term;
    end
  end

endmodule

[rtl/tet_checker.sv]
// port-level checks of the text encoding transcoder, bound to the top level
// depends on text_encoding_transcoder_top_defines.svh
`include "text_encoding_transcoder_top_defines.svh"

module tet_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic [7:0] in_tdata,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tuser,
  input logic       out_tlast,
  input logic       cfg_we,
  input logic       cfg_index,
  input logic [1:0] cfg_wdata
);

  // a stalled output item holds its byte and flags
  `TET_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "stalled output item changed")

  // end of string only on the final byte of a run
  `TET_ASSERT(a_eos_last, clk, rst_n, out_tvalid && out_tuser |-> out_tlast, "end of string off the last byte")

  // no new source item while a stalled character is pending
  `TET_ASSERT(a_in_blocked, clk, rst_n, out_tvalid && !out_tready |-> !in_tready, "input taken while output stalled")

  // reset empties the output register
  `TET_ASSERT_ALWAYS(a_rst_empty, clk, !rst_n |=> !out_tvalid, "output valid after reset")

endmodule

bind text_encoding_transcoder_top tet_checker u_tet_checker (.*);

[tb/testbench.sv]
// self-checking testbench of the text encoding transcoder (cp866 / utf-16le / utf-8)
// depends on tet_pkg and text_encoding_transcoder_top; a built-in predictor checks every byte
`timescale 1ns / 100ps

module testbench;
  import tet_pkg::*;

  // cp866 can also be selected by the spare code
  localparam logic [1:0]  ENC_CP866_ALT = 2'd1;
  localparam logic [20:0] QMARK         = 21'h3F;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = 4;
  localparam int SEG_ITEMS     = 11;

  // one destination byte as the block reports it
  typedef struct packed {
    logic [7:0] data;
    logic       eos;
    logic       last;
  } out_byte_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tuser;
  logic       out_tlast;
  logic       cfg_we = 1'b0;
  logic       cfg_index = CFG_SRC;
  logic [1:0] cfg_wdata = ENC_CP866;

  // predictor copy of the registers and the partial character
  logic [1:0]  src_enc = ENC_CP866;
  logic [1:0]  dst_enc = ENC_CP866;
  logic [20:0] partial_cp = '0;
  logic [1:0]  cont_left = '0;
  logic        low_held = 1'b0;

  out_byte_t expected_bytes[$];

  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_cycles = 0;
  int mismatch_count = 0;
  int bytes_sent = 0;
  int bytes_checked = 0;
  int settings_used = 0;
  int cycle_count = 0;

  text_encoding_transcoder_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [7:0] in_byte
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [7:0] out_byte
    .out_tuser  (out_tuser),   // [0] end_of_string
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d bytes outstanding", cycle_count,
               expected_bytes.size());
      $display("status: fail");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  function automatic void clear_partial();
    partial_cp = '0;
    cont_left  = '0;
    low_held   = 1'b0;
  endfunction

  // decode one source byte, queue the destination bytes of a finished character
  function automatic void transcode_byte(input logic [7:0] b);
    logic [20:0] cp;
    logic [7:0]  enc [4];
    int          n;
    logic        term;
    cp = '0;
    n  = 1;
    case (src_enc)
      ENC_UTF16: begin
        if (!low_held) begin
          partial_cp = {13'd0, b};
          low_held   = 1'b1;
          return;
        end
        cp = {5'd0, b, partial_cp[7:0]};
        clear_partial();
      end
      ENC_UTF8: begin
        if (cont_left != 2'd0) begin
          // continuation form is not checked, low six bits are taken
          partial_cp = {partial_cp[14:0], b[5:0]};
          cont_left  = cont_left - 2'd1;
          if (cont_left != 2'd0) return;
          cp = partial_cp;
          clear_partial();
        end else if (b < 8'h80) begin
          cp = {13'd0, b};
        end else if (b < 8'hC0 || b >= 8'hF8) begin
          cp = QMARK;
        end else begin
          if (b < 8'hE0) begin
            partial_cp = {16'd0, b[4:0]};
            cont_left  = 2'd1;
          end else if (b < 8'hF0) begin
            partial_cp = {17'd0, b[3:0]};
            cont_left  = 2'd2;
          end else begin
            partial_cp = {18'd0, b[2:0]};
            cont_left  = 2'd3;
          end
          return;
        end
      end
      default: begin
        if (b < 8'h80)       cp = {13'd0, b};
        else if (b < 8'hB0)  cp = {13'd0, b} + 21'h390;
        else if (b < 8'hE0)  cp = QMARK;
        else if (b < 8'hF0)  cp = {13'd0, b} + 21'h360;
        else if (b == 8'hF0) cp = 21'h401;
        else if (b == 8'hF1) cp = 21'h451;
        else                 cp = QMARK;
      end
    endcase

    // a zero character is the terminator and drops any partial state
    term = (cp == 21'd0);
    if (term) clear_partial();

    case (dst_enc)
      ENC_UTF16: begin
        enc[0] = cp[7:0];
        enc[1] = cp[15:8];
        n = 2;
      end
      ENC_UTF8: begin
        if (cp < 21'h80) begin
          enc[0] = cp[7:0];
        end else if (cp < 21'h800) begin
          enc[0] = {3'b110, cp[10:6]};
          enc[1] = {2'b10, cp[5:0]};
          n = 2;
        end else if (cp < 21'h10000) begin
          enc[0] = {4'b1110, cp[15:12]};
          enc[1] = {2'b10, cp[11:6]};
          enc[2] = {2'b10, cp[5:0]};
          n = 3;
        end else begin
          enc[0] = {5'b11110, cp[20:18]};
          enc[1] = {2'b10, cp[17:12]};
          enc[2] = {2'b10, cp[11:6]};
          enc[3] = {2'b10, cp[5:0]};
          n = 4;
        end
      end
      default: begin
        if (cp < 21'h80)                        enc[0] = cp[7:0];
        else if (cp == 21'h401)                 enc[0] = 8'hF0;
        else if (cp < 21'h410)                  enc[0] = QMARK[7:0];
        else if (cp < 21'h440)                  enc[0] = 8'(cp - 21'h390);
        else if (cp < 21'h450)                  enc[0] = 8'(cp - 21'h360);
        else if (cp == 21'h451)                 enc[0] = 8'hF1;
        else                                    enc[0] = QMARK[7:0];
      end
    endcase

    for (int k = 0; k < n; k++)
      expected_bytes.push_back('{enc[k], term && (k == n - 1), k == n - 1});
  endfunction

  // compare one accepted destination byte with the oldest prediction
  task automatic check_out_byte();
    out_byte_t want;
    if (expected_bytes.size() == 0) begin
      report_mismatch($sformatf("unexpected byte %h tuser %b tlast %b",
                                out_tdata, out_tuser, out_tlast));
      return;
    end
    want = expected_bytes.pop_front();
    if (out_tdata !== want.data)
      report_mismatch($sformatf("byte %h, want %h", out_tdata, want.data));
    if (out_tuser !== want.eos)
      report_mismatch($sformatf("end of string %b, want %b (byte %h)", out_tuser, want.eos,
                                want.data));
    if (out_tlast !== want.last)
      report_mismatch($sformatf("last %b, want %b (byte %h)", out_tlast, want.last, want.data));
    bytes_checked++;
  endtask

  // receiver: check at each handshake, then decide the next ready
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) check_out_byte();
    if (hold_cycles > 0) begin
      out_tready <= 1'b0;
      hold_cycles--;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // offer one source byte, with random idle cycles ahead of it
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    transcode_byte(b);
    bytes_sent++;
  endtask

  // stop offering and wait for every predicted byte
  task automatic drain_results();
    int waited;
    waited = 0;
    in_tvalid <= 1'b0;
    while (expected_bytes.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_bytes.size() != 0) begin
      report_mismatch($sformatf("%0d predicted bytes never came", expected_bytes.size()));
      expected_bytes.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [1:0] val);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_SRC) src_enc = val;
    else dst_enc = val;
    clear_partial();
  endtask

  task automatic set_encodings(input logic [1:0] src, input logic [1:0] dst);
    write_reg(CFG_SRC, src);
    write_reg(CFG_DST, dst);
    settings_used++;
  endtask

  // idle modes: none, sender only, receiver only, both light
  task automatic set_idling(input int mode);
    case (mode)
      1:       begin send_idle_pct = 58; stall_pct = 0;  end
      2:       begin send_idle_pct = 0;  stall_pct = 58; end
      3:       begin send_idle_pct = 7;  stall_pct = 7;  end
      default: begin send_idle_pct = 0;  stall_pct = 0;  end
    endcase
  endtask

  // one character of random content under the current source encoding
  task automatic send_random_char();
    int          pick;
    int          len;
    logic [7:0]  lead;
    logic [15:0] unit;
    pick = $urandom_range(99);
    case (src_enc)
      ENC_UTF8: begin
        if (pick < 8) begin
          send_byte(8'($urandom_range(255)));
        end else if (pick < 12) begin
          send_byte(8'h00);
        end else begin
          len = $urandom_range(1, 4);
          case (len)
            1: lead = 8'($urandom_range(8'h01, 8'h7F));
            2: lead = pick[0] ? 8'($urandom_range(8'hD0, 8'hD1))
                              : 8'($urandom_range(8'hC0, 8'hDF));
            3: lead = 8'($urandom_range(8'hE0, 8'hEF));
            default: lead = 8'($urandom_range(8'hF0, 8'hF7));
          endcase
          send_byte(lead);
          // broken sequences lose their tail, some carry random bytes in place of continuation bytes
          for (int k = 1; k < len - (pick < 20 ? 1 : 0); k++)
            send_byte(pick < 25 ? 8'($urandom_range(255)) : {2'b10, 6'($urandom_range(63))});
        end
      end
      ENC_UTF16: begin
        if (pick < 8)       unit = 16'h0000;
        else if (pick < 50) unit = 16'h0400 + 16'($urandom_range(8'h5F));
        else if (pick < 75) unit = 16'($urandom_range(1, 8'h7F));
        else                unit = 16'($urandom_range(16'hFFFF));
        send_byte(unit[7:0]);
        send_byte(unit[15:8]);
      end
      default: send_byte(pick < 5 ? 8'h00 : 8'($urandom_range(255)));
    endcase
  endtask

  // cp866 both ways straight out of reset
  task automatic test_reset_defaults();
    set_idling(0);
    send_byte(8'hA0);
    send_byte(8'hB5);
    send_byte(8'h00);
    settings_used++;
  endtask

  // cp866 source: ascii, both cyrillic blocks, yo, unmapped bytes
  task automatic test_cp866_source();
    set_encodings(ENC_CP866_ALT, ENC_UTF8);
    send_byte(8'h41);
    send_byte(8'h80);
    send_byte(8'hB0);
    send_byte(8'hEF);
    send_byte(8'hF1);
    send_byte(8'hFF);
  endtask

  // utf-8 source: overlong zero, two-byte yo, invalid leads
  task automatic test_utf8_source();
    set_encodings(ENC_UTF8, ENC_CP866);
    send_byte(8'hC0);
    send_byte(8'h80);
    send_byte(8'hD0);
    send_byte(8'h81);
    send_byte(8'h80);
    send_byte(8'hF8);
  endtask

  // code points past 16 bits into utf-8 and utf-16, plus the wide terminator
  task automatic test_wide_code_points();
    set_encodings(ENC_UTF8, ENC_UTF8);
    send_byte(8'hF7);
    send_byte(8'hBF);
    send_byte(8'hBF);
    send_byte(8'hBF);
    set_encodings(ENC_UTF8, ENC_UTF16);
    send_byte(8'hF4);
    send_byte(8'h8F);
    send_byte(8'hBF);
    send_byte(8'hBF);
    send_byte(8'h00);
  endtask

  task automatic test_utf16_source();
    set_encodings(ENC_UTF16, ENC_CP866_ALT);
    send_byte(8'h01);
    send_byte(8'h04);
  endtask

  // a register write drops a half-received character
  task automatic test_abandoned_char();
    set_encodings(ENC_UTF8, ENC_CP866);
    send_byte(8'hE0);
    write_reg(CFG_DST, ENC_UTF16);
    send_byte(8'h41);
  endtask

  // long receiver hold-off fills the block, then a full pause of the sender
  task automatic test_backpressure();
    set_encodings(ENC_CP866, ENC_UTF8);
    set_idling(0);
    hold_cycles = 80;
    for (int k = 0; k < 24; k++) send_byte(8'($urandom_range(8'h80, 8'hAF)));
    drain_results();
    for (int k = 0; k < 6; k++) send_random_char();
  endtask

  // random streams across settings and idle modes
  task automatic test_random_streams();
    logic [1:0] seg_src [8];
    logic [1:0] seg_dst [8];
    int         target;
    seg_src = '{ENC_UTF8, ENC_UTF8, ENC_UTF16, ENC_CP866, ENC_UTF8, ENC_UTF16,
                ENC_CP866_ALT, ENC_UTF8};
    seg_dst = '{ENC_UTF8, ENC_UTF16, ENC_UTF8, ENC_UTF8, ENC_CP866, ENC_UTF16,
                ENC_UTF16, ENC_CP866_ALT};
    for (int seg = 0; seg < 8; seg++) begin
      set_encodings(seg_src[seg], seg_dst[seg]);
      set_idling(seg % 4);
      target = bytes_sent + SEG_ITEMS;
      while (bytes_sent < target) send_random_char();
    end
    set_idling(0);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_cp866_source();
    test_utf8_source();
    test_wide_code_points();
    test_utf16_source();
    test_abandoned_char();
    test_backpressure();
    test_random_streams();
    drain_results();
    repeat (10) @(posedge clk);
    $display("covered %0d source bytes and %0d checked destination bytes", bytes_sent,
             bytes_checked);
    $display("over %0d encoding settings with idle, stall and hold-off phases", settings_used);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("status: fail");
    end
    $finish;
  end

endmodule
